>>> design/bfpe_pkg.sv
// Shared definitions for the Brainfuck program executor: command codes,
// instruction characters, controller states and the result word type.
// Standalone package with no dependencies.
`timescale 1ns / 1ps

package bfpe_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_STEP    = 2'd3
  } cmd_e;

  localparam logic [7:0] OP_RIGHT = 8'h3E;
  localparam logic [7:0] OP_LEFT  = 8'h3C;
  localparam logic [7:0] OP_INC   = 8'h2B;
  localparam logic [7:0] OP_DEC   = 8'h2D;
  localparam logic [7:0] OP_OUT   = 8'h2E;
  localparam logic [7:0] OP_IN    = 8'h2C;
  localparam logic [7:0] OP_LOOP  = 8'h5B;
  localparam logic [7:0] OP_BACK  = 8'h5D;
  localparam logic [7:0] OP_END   = 8'h00;

  typedef enum logic [6:0] {
    ST_SWEEP     = 7'b0000001,
    ST_IDLE      = 7'b0000010,
    ST_EXEC      = 7'b0000100,
    ST_SCAN_ADDR = 7'b0001000,
    ST_SCAN_EVAL = 7'b0010000,
    ST_CHECK     = 7'b0100000,
    ST_RESP      = 7'b1000000
  } state_e;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       input_taken;
    logic       halted;
    logic       run_error;
    logic [1:0] syntax_status;
    logic       program_full;
  } res_t;

  function automatic logic is_legal(input logic [7:0] ch);
    return (ch == OP_RIGHT) || (ch == OP_LEFT) || (ch == OP_INC) || (ch == OP_DEC) ||
           (ch == OP_OUT) || (ch == OP_IN) || (ch == OP_LOOP) || (ch == OP_BACK) ||
           (ch == OP_END);
  endfunction

endpackage

>>> design/bfpe_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used for both the program store and the tape. No package dependencies.
`timescale 1ns / 1ps

module bfpe_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/brainfuck_program_executor.sv
// Brainfuck program executor: done_o rises after clear and load once the CHECK and RESP states
// have passed, and after a step once EXEC, any bracket scan (SCAN_ADDR and SCAN_EVAL for each
// character walked), CHECK and RESP have passed; busy_o drops with it, so a new command can follow.
// Restart also sweeps the tape to zero, one cell per cycle, before CHECK and RESP.
// After reset the block is busy while the tape is cleared. Each result
// word is shown for one cycle on done_o; the receiver cannot stall it. Uses bfpe_pkg, bfpe_ram.
`timescale 1ns / 1ps

module brainfuck_program_executor #(
  parameter int unsigned PROG_DEPTH = 4096,
  parameter int unsigned TAPE_DEPTH = 32768
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] command_i,
  input  logic [7:0] data_byte_i,
  output logic       done_o,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       input_taken_o,
  output logic       halted_o,
  output logic       run_error_o,
  output logic [1:0] syntax_status_o,
  output logic       program_full_o
);

  localparam int unsigned PW = $clog2(PROG_DEPTH);
  localparam int unsigned LW = $clog2(PROG_DEPTH + 1);
  localparam int unsigned TW = $clog2(TAPE_DEPTH);

  bfpe_pkg::state_e state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] open_q, open_d;
  logic [LW-1:0] close_q, close_d;
  logic          ill_q, ill_d;
  logic [TW-1:0] dp_q, dp_d;
  logic [LW-1:0] pc_q, pc_d;
  logic          err_q, err_d;
  logic [LW-1:0] scan_q, scan_d;
  logic [LW-1:0] depth_q, depth_d;
  logic          back_q, back_d;
  logic [TW-1:0] sweep_q, sweep_d;
  logic          pend_q, pend_d;
  logic          done_q, done_d;
  logic [7:0]    byte_q, byte_d;
  bfpe_pkg::res_t res_q, res_d;

  logic          prog_we;
  logic [PW-1:0] prog_waddr;
  logic [7:0]    prog_wdata;
  logic [PW-1:0] prog_raddr;
  logic [7:0]    prog_rdata;
  logic          tape_we;
  logic [TW-1:0] tape_waddr;
  logic [7:0]    tape_wdata;
  logic [7:0]    tape_rdata;

  logic [1:0]    syn;
  logic [LW-1:0] pc_inc;
  logic [LW-1:0] depth_nx;

  bfpe_ram #(
    .DEPTH(PROG_DEPTH),
    .WIDTH(8)
  ) u_prog (
    .clk_i  (clk_i),
    .we_i   (prog_we),
    .waddr_i(prog_waddr),
    .wdata_i(prog_wdata),
    .raddr_i(prog_raddr),
    .rdata_o(prog_rdata)
  );

  bfpe_ram #(
    .DEPTH(TAPE_DEPTH),
    .WIDTH(8)
  ) u_tape (
    .clk_i  (clk_i),
    .we_i   (tape_we),
    .waddr_i(tape_waddr),
    .wdata_i(tape_wdata),
    .raddr_i(dp_q),
    .rdata_o(tape_rdata)
  );

  assign syn        = {ill_q, (open_q != close_q)};
  assign pc_inc     = pc_q + LW'(1);
  assign prog_raddr = (state_q == bfpe_pkg::ST_SCAN_ADDR) ? scan_q[PW-1:0] : pc_q[PW-1:0];
  assign prog_waddr = len_q[PW-1:0];
  assign prog_wdata = data_byte_i;

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    open_d     = open_q;
    close_d    = close_q;
    ill_d      = ill_q;
    dp_d       = dp_q;
    pc_d       = pc_q;
    err_d      = err_q;
    scan_d     = scan_q;
    depth_d    = depth_q;
    back_d     = back_q;
    sweep_d    = sweep_q;
    pend_d     = pend_q;
    done_d     = 1'b0;
    byte_d     = byte_q;
    res_d      = res_q;
    prog_we    = 1'b0;
    tape_we    = 1'b0;
    tape_waddr = dp_q;
    tape_wdata = 8'd0;
    depth_nx   = depth_q;
    case (state_q)
      bfpe_pkg::ST_SWEEP: begin
        tape_we    = 1'b1;
        tape_waddr = sweep_q;
        tape_wdata = 8'd0;
        if (sweep_q == TW'(TAPE_DEPTH - 1)) begin
          sweep_d = '0;
          pend_d  = 1'b0;
          state_d = pend_q ? bfpe_pkg::ST_CHECK : bfpe_pkg::ST_IDLE;
        end else begin
          sweep_d = sweep_q + TW'(1);
        end
      end
      bfpe_pkg::ST_IDLE: begin
        if (start_i) begin
          res_d.out_valid    = 1'b0;
          res_d.out_byte     = 8'd0;
          res_d.input_taken  = 1'b0;
          res_d.program_full = 1'b0;
          byte_d             = data_byte_i;
          state_d            = bfpe_pkg::ST_CHECK;
          case (bfpe_pkg::cmd_e'(command_i))
            bfpe_pkg::CMD_CLEAR: begin
              len_d   = '0;
              open_d  = '0;
              close_d = '0;
              ill_d   = 1'b0;
              pc_d    = '0;
              err_d   = 1'b0;
            end
            bfpe_pkg::CMD_LOAD: begin
              if (len_q == LW'(PROG_DEPTH)) begin
                res_d.program_full = 1'b1;
              end else begin
                prog_we = 1'b1;
                len_d   = len_q + LW'(1);
                if (data_byte_i == bfpe_pkg::OP_LOOP) begin
                  open_d = open_q + LW'(1);
                end else if (data_byte_i == bfpe_pkg::OP_BACK) begin
                  close_d = close_q + LW'(1);
                end
                if (!bfpe_pkg::is_legal(data_byte_i)) begin
                  ill_d = 1'b1;
                end
              end
            end
            bfpe_pkg::CMD_RESTART: begin
              pc_d    = '0;
              dp_d    = '0;
              err_d   = 1'b0;
              pend_d  = 1'b1;
              sweep_d = '0;
              state_d = bfpe_pkg::ST_SWEEP;
            end
            bfpe_pkg::CMD_STEP: begin
              state_d = bfpe_pkg::ST_EXEC;
            end
            default: begin
              state_d = bfpe_pkg::ST_CHECK;
            end
          endcase
        end
      end
      bfpe_pkg::ST_EXEC: begin
        state_d = bfpe_pkg::ST_CHECK;
        if ((syn == 2'd0) && !err_q && (pc_q < len_q) && (prog_rdata != bfpe_pkg::OP_END)) begin
          case (prog_rdata)
            bfpe_pkg::OP_LEFT: begin
              dp_d = (dp_q == '0) ? TW'(TAPE_DEPTH - 1) : dp_q - TW'(1);
              pc_d = pc_inc;
            end
            bfpe_pkg::OP_RIGHT: begin
              dp_d = (dp_q == TW'(TAPE_DEPTH - 1)) ? '0 : dp_q + TW'(1);
              pc_d = pc_inc;
            end
            bfpe_pkg::OP_INC: begin
              tape_we    = 1'b1;
              tape_wdata = tape_rdata + 8'd1;
              pc_d       = pc_inc;
            end
            bfpe_pkg::OP_DEC: begin
              tape_we    = 1'b1;
              tape_wdata = tape_rdata - 8'd1;
              pc_d       = pc_inc;
            end
            bfpe_pkg::OP_IN: begin
              tape_we           = 1'b1;
              tape_wdata        = byte_q;
              res_d.input_taken = 1'b1;
              pc_d              = pc_inc;
            end
            bfpe_pkg::OP_OUT: begin
              res_d.out_valid = 1'b1;
              res_d.out_byte  = tape_rdata;
              pc_d            = pc_inc;
            end
            bfpe_pkg::OP_LOOP: begin
              if (tape_rdata != 8'd0) begin
                pc_d = pc_inc;
              end else begin
                scan_d  = pc_inc;
                depth_d = LW'(1);
                back_d  = 1'b0;
                state_d = bfpe_pkg::ST_SCAN_ADDR;
              end
            end
            bfpe_pkg::OP_BACK: begin
              if (tape_rdata == 8'd0) begin
                pc_d = pc_inc;
              end else if (pc_q == '0) begin
                err_d = 1'b1;
              end else begin
                scan_d  = pc_q - LW'(1);
                depth_d = LW'(1);
                back_d  = 1'b1;
                state_d = bfpe_pkg::ST_SCAN_ADDR;
              end
            end
            default: begin
              pc_d = pc_inc;
            end
          endcase
        end
      end
      bfpe_pkg::ST_SCAN_ADDR: begin
        if (scan_q >= len_q) begin
          err_d   = 1'b1;
          state_d = bfpe_pkg::ST_CHECK;
        end else begin
          state_d = bfpe_pkg::ST_SCAN_EVAL;
        end
      end
      bfpe_pkg::ST_SCAN_EVAL: begin
        if (prog_rdata == bfpe_pkg::OP_END) begin
          err_d   = 1'b1;
          state_d = bfpe_pkg::ST_CHECK;
        end else begin
          if (prog_rdata == bfpe_pkg::OP_LOOP) begin
            depth_nx = back_q ? depth_q - LW'(1) : depth_q + LW'(1);
          end else if (prog_rdata == bfpe_pkg::OP_BACK) begin
            depth_nx = back_q ? depth_q + LW'(1) : depth_q - LW'(1);
          end
          depth_d = depth_nx;
          if (depth_nx == '0) begin
            pc_d    = scan_q + LW'(1);
            state_d = bfpe_pkg::ST_CHECK;
          end else if (back_q) begin
            if (scan_q == '0) begin
              err_d   = 1'b1;
              state_d = bfpe_pkg::ST_CHECK;
            end else begin
              scan_d  = scan_q - LW'(1);
              state_d = bfpe_pkg::ST_SCAN_ADDR;
            end
          end else begin
            scan_d  = scan_q + LW'(1);
            state_d = bfpe_pkg::ST_SCAN_ADDR;
          end
        end
      end
      bfpe_pkg::ST_CHECK: begin
        state_d = bfpe_pkg::ST_RESP;
      end
      bfpe_pkg::ST_RESP: begin
        res_d.halted        = err_q || !(pc_q < len_q) || (prog_rdata == bfpe_pkg::OP_END);
        res_d.run_error     = err_q;
        res_d.syntax_status = syn;
        done_d              = 1'b1;
        state_d             = bfpe_pkg::ST_IDLE;
      end
      default: begin
        state_d = bfpe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfpe_pkg::ST_SWEEP;
      len_q   <= '0;
      open_q  <= '0;
      close_q <= '0;
      ill_q   <= 1'b0;
      dp_q    <= '0;
      pc_q    <= '0;
      err_q   <= 1'b0;
      back_q  <= 1'b0;
      sweep_q <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      open_q  <= open_d;
      close_q <= close_d;
      ill_q   <= ill_d;
      dp_q    <= dp_d;
      pc_q    <= pc_d;
      err_q   <= err_d;
      back_q  <= back_d;
      sweep_q <= sweep_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q  <= scan_d;
    depth_q <= depth_d;
    byte_q  <= byte_d;
    res_q   <= res_d;
  end

  assign busy_o          = (state_q != bfpe_pkg::ST_IDLE);
  assign done_o          = done_q;
  assign out_valid_o     = res_q.out_valid;
  assign out_byte_o      = res_q.out_byte;
  assign input_taken_o   = res_q.input_taken;
  assign halted_o        = res_q.halted;
  assign run_error_o     = res_q.run_error;
  assign syntax_status_o = res_q.syntax_status;
  assign program_full_o  = res_q.program_full;

  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= len_q)
    else $error("program counter beyond program length");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not make the block busy");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && run_error_o) |-> halted_o)
    else $error("run error reported without halt");

  a_io_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(out_valid_o && input_taken_o))
    else $error("one step both emitted and consumed a byte");

endmodule
